### design/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg: shared definitions for the packed 2bpp framebuffer
// Geometry constants, command codes, address helper and the control and
// status structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pfb_pkg;

    localparam int COLUMNS    = 128;
    localparam int ROWS       = 128;
    localparam int BYTE_ROWS  = (ROWS + 3) / 4;
    localparam int STORE_SIZE = BYTE_ROWS * COLUMNS;

    localparam int COORD_W = 7;
    localparam int ADDR_W  = $clog2(STORE_SIZE);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int BR_W    = (BYTE_ROWS > 1) ? $clog2(BYTE_ROWS) : 1;
    // Counter widths hold both any input coordinate plus seven and the limit itself.
    localparam int XC_W = ((COORD_W + 1) > $clog2(COLUMNS + 1)) ?
                          (COORD_W + 1) : $clog2(COLUMNS + 1);
    localparam int YC_W = ((COORD_W + 1) > $clog2(ROWS + 1)) ?
                          (COORD_W + 1) : $clog2(ROWS + 1);

    localparam logic [2:0] CMD_FILL   = 3'd0;
    localparam logic [2:0] CMD_INVERT = 3'd1;
    localparam logic [2:0] CMD_BITMAP = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_ACK    = 3'd4;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic rect_step;
        logic bmp_step;
        logic result_load;
    } pfb_ctl_t;

    typedef struct packed {
        logic clr_last;
        logic rect_empty;
        logic bmp_empty;
        logic rect_last;
        logic bmp_last;
        logic out_free;
    } pfb_status_t;

    function automatic logic [ADDR_W-1:0] make_addr(input logic [BR_W-1:0] br,
                                                    input logic [COL_W-1:0] col);
        int unsigned full;
        full = int'(br) * COLUMNS + int'(col);
        return full[ADDR_W-1:0];
    endfunction

endpackage

### design/pfb_ctrl.sv
// ----------------------------------------------------------------------------
// pfb_ctrl: command sequencer for the packed 2bpp framebuffer
// Runs the clearing sweep after reset, then steps each command through its
// scan, drain and result phases.
// ----------------------------------------------------------------------------
module pfb_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           cmd,
    input  pfb_pkg::pfb_status_t sts,
    output pfb_pkg::pfb_ctl_t    ctl
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_RECT   = 3'd2;
    localparam logic [2:0] ST_BMP    = 3'd3;
    localparam logic [2:0] ST_WAIT   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    case (cmd)
                        pfb_pkg::CMD_FILL, pfb_pkg::CMD_INVERT:
                            state_next = sts.rect_empty ? ST_FINISH : ST_RECT;
                        pfb_pkg::CMD_BITMAP:
                            state_next = sts.bmp_empty ? ST_FINISH : ST_BMP;
                        pfb_pkg::CMD_READ:
                            state_next = ST_WAIT;
                        default:
                            state_next = ST_FINISH;
                    endcase
                end
            end
            ST_RECT:
            begin
                ctl.rect_step = 1'b1;
                if (sts.rect_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_BMP:
            begin
                ctl.bmp_step = 1'b1;
                if (sts.bmp_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                // The last write lands, or the read data settles, in this cycle.
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    ctl.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    property p_load_only_idle;
        @(posedge clk) disable iff (!rst_n)
        ctl.load |-> (state_reg == ST_IDLE);
    endproperty
    a_load_only_idle: assert property (p_load_only_idle)
        else $error("command loaded outside idle");

    property p_no_accept_while_clearing;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready;
    endproperty
    a_no_accept_while_clearing: assert property (p_no_accept_while_clearing)
        else $error("input accepted during clearing sweep");

    property p_scan_ends_in_wait;
        @(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RECT) && sts.rect_last) |=> (state_reg == ST_WAIT);
    endproperty
    a_scan_ends_in_wait: assert property (p_scan_ends_in_wait)
        else $error("rectangle scan did not drain");

endmodule

### design/pfb_dpath.sv
// ----------------------------------------------------------------------------
// pfb_dpath: pixel store and read-modify-write datapath
// Holds the byte store, the scan counters, the write-back stage, the refresh
// flag and the result register.
// ----------------------------------------------------------------------------
module pfb_dpath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfb_pkg::pfb_ctl_t             ctl,
    output pfb_pkg::pfb_status_t          sts,
    input  logic [2:0]                    cmd,
    input  logic [pfb_pkg::COORD_W-1:0]   x_first,
    input  logic [pfb_pkg::COORD_W-1:0]   y_first,
    input  logic [pfb_pkg::COORD_W-1:0]   x_last,
    input  logic [pfb_pkg::COORD_W-1:0]   y_last,
    input  logic [1:0]                    colour,
    input  logic [7:0]                    bitmap_bits,
    input  logic [3:0]                    bit_count,
    input  logic                          invert_bits,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    read_byte,
    output logic                          refresh_pending,
    output logic                          clipped
);

    localparam int XC_W   = pfb_pkg::XC_W;
    localparam int YC_W   = pfb_pkg::YC_W;
    localparam int ADDR_W = pfb_pkg::ADDR_W;
    localparam int COL_W  = pfb_pkg::COL_W;
    localparam int BR_W   = pfb_pkg::BR_W;

    logic [7:0] mem [pfb_pkg::STORE_SIZE];

    // Control registers.
    logic              dirty_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              s1_valid_reg;
    logic              out_valid_reg;

    // Payload registers.
    logic [XC_W-1:0]   xf_reg;
    logic [XC_W-1:0]   x_end_reg;
    logic [YC_W-1:0]   yf_reg;
    logic [YC_W-1:0]   y_end_reg;
    logic [XC_W-1:0]   col_cnt_reg;
    logic [BR_W-1:0]   br_cnt_reg;
    logic [1:0]        colour_reg;
    logic              inv_mode_reg;
    logic              is_read_reg;
    logic              rd_ok_reg;
    logic [7:0]        bits_reg;
    logic [3:0]        count_reg;
    logic              clip_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [3:0]        s1_mask_reg;
    logic [1:0]        s1_pix_reg;
    logic              s1_inv_reg;
    logic [7:0]        rd_data_reg;
    logic [7:0]        read_byte_reg;
    logic              refresh_reg;
    logic              clipped_reg;

    // Input decode for the loading cycle.
    logic [XC_W-1:0]   xf_in;
    logic [XC_W-1:0]   xl_in;
    logic [YC_W-1:0]   yf_in;
    logic [YC_W-1:0]   yl_in;
    logic [XC_W-1:0]   x_end_in;
    logic [YC_W-1:0]   y_end_in;
    logic              read_ok_in;
    logic [3:0]        count_in;

    // Scan decode.
    logic [BR_W-1:0]   br_first;
    logic [BR_W-1:0]   br_last;
    logic [1:0]        slot_lo;
    logic [1:0]        slot_hi;
    logic [3:0]        rect_mask;
    logic              bmp_in;
    logic              col_done;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        merged;

    assign xf_in = XC_W'(x_first);
    assign xl_in = XC_W'(x_last);
    assign yf_in = YC_W'(y_first);
    assign yl_in = YC_W'(y_last);
    assign x_end_in = (xl_in > XC_W'(pfb_pkg::COLUMNS - 1)) ?
                      XC_W'(pfb_pkg::COLUMNS - 1) : xl_in;
    assign y_end_in = (yl_in > YC_W'(pfb_pkg::ROWS - 1)) ?
                      YC_W'(pfb_pkg::ROWS - 1) : yl_in;
    assign read_ok_in = (xf_in < XC_W'(pfb_pkg::COLUMNS)) &&
                        ((yf_in >> 2) < YC_W'(pfb_pkg::BYTE_ROWS));
    assign count_in = (bit_count > 4'd8) ? 4'd8 : bit_count;

    assign br_first = BR_W'(yf_reg >> 2);
    assign br_last  = BR_W'(y_end_reg >> 2);
    assign slot_lo  = (br_cnt_reg == br_first) ? yf_reg[1:0] : 2'd0;
    assign slot_hi  = (br_cnt_reg == br_last) ? y_end_reg[1:0] : 2'd3;
    assign col_done = (col_cnt_reg == x_end_reg);
    assign bmp_in   = (col_cnt_reg < XC_W'(pfb_pkg::COLUMNS)) &&
                      (yf_reg < YC_W'(pfb_pkg::ROWS));

    always_comb
    begin
        for (int s = 0; s < 4; s++)
        begin
            rect_mask[s] = (2'(s) >= slot_lo) && (2'(s) <= slot_hi);
        end
    end

    assign sts.clr_last   = (clr_cnt_reg == ADDR_W'(pfb_pkg::STORE_SIZE - 1));
    assign sts.rect_empty = (xf_in > xl_in) || (xf_in >= XC_W'(pfb_pkg::COLUMNS)) ||
                            (yf_in > yl_in) || (yf_in >= YC_W'(pfb_pkg::ROWS));
    assign sts.bmp_empty  = (bit_count == 4'd0);
    assign sts.rect_last  = col_done && (br_cnt_reg == br_last);
    assign sts.bmp_last   = (count_reg == 4'd1);
    assign sts.out_free   = !out_valid_reg || out_ready;

    // Read port address: the read command uses the inputs directly.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = pfb_pkg::make_addr(br_cnt_reg, COL_W'(col_cnt_reg));
        if (ctl.load)
        begin
            rd_en   = (cmd == pfb_pkg::CMD_READ) && read_ok_in;
            rd_addr = pfb_pkg::make_addr(BR_W'(yf_in >> 2), COL_W'(xf_in));
        end
        else if (ctl.rect_step)
        begin
            rd_en = 1'b1;
        end
        else if (ctl.bmp_step)
        begin
            rd_en   = bmp_in;
            rd_addr = pfb_pkg::make_addr(BR_W'(yf_reg >> 2), COL_W'(col_cnt_reg));
        end
    end

    // Merge of the fetched byte with the pending pixel slots.
    always_comb
    begin
        merged = rd_data_reg;
        for (int s = 0; s < 4; s++)
        begin
            if (s1_mask_reg[s])
            begin
                if (s1_inv_reg)
                begin
                    merged[2*s +: 2] = (rd_data_reg[2*s +: 2] == 2'd0) ? s1_pix_reg : 2'd0;
                end
                else
                begin
                    merged[2*s +: 2] = s1_pix_reg;
                end
            end
        end
    end

    assign wr_en   = ctl.clr_step || s1_valid_reg;
    assign wr_addr = ctl.clr_step ? clr_cnt_reg : s1_addr_reg;
    assign wr_data = ctl.clr_step ? 8'd0 : merged;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg     <= 1'b0;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (ctl.load)
            begin
                if ((cmd == pfb_pkg::CMD_FILL) || (cmd == pfb_pkg::CMD_INVERT) ||
                    (cmd == pfb_pkg::CMD_BITMAP))
                begin
                    dirty_reg <= 1'b1;
                end
                else if (cmd == pfb_pkg::CMD_ACK)
                begin
                    dirty_reg <= 1'b0;
                end
            end
            s1_valid_reg <= ctl.rect_step || (ctl.bmp_step && bmp_in);
            if (ctl.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            xf_reg       <= xf_in;
            x_end_reg    <= x_end_in;
            yf_reg       <= yf_in;
            y_end_reg    <= y_end_in;
            col_cnt_reg  <= xf_in;
            br_cnt_reg   <= BR_W'(yf_in >> 2);
            colour_reg   <= colour;
            inv_mode_reg <= (cmd == pfb_pkg::CMD_INVERT);
            is_read_reg  <= (cmd == pfb_pkg::CMD_READ);
            rd_ok_reg    <= read_ok_in;
            bits_reg     <= bitmap_bits ^ {8{invert_bits}};
            count_reg    <= count_in;
            clip_reg     <= 1'b0;
        end
        else if (ctl.rect_step)
        begin
            if (col_done)
            begin
                col_cnt_reg <= xf_reg;
                br_cnt_reg  <= br_cnt_reg + 1'b1;
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + 1'b1;
            end
        end
        else if (ctl.bmp_step)
        begin
            col_cnt_reg <= col_cnt_reg + 1'b1;
            bits_reg    <= {bits_reg[6:0], 1'b0};
            count_reg   <= count_reg - 1'b1;
            if (col_cnt_reg >= XC_W'(pfb_pkg::COLUMNS))
            begin
                clip_reg <= 1'b1;
            end
        end

        if (ctl.rect_step)
        begin
            s1_addr_reg <= rd_addr;
            s1_mask_reg <= rect_mask;
            s1_pix_reg  <= colour_reg;
            s1_inv_reg  <= inv_mode_reg;
        end
        else if (ctl.bmp_step)
        begin
            s1_addr_reg <= rd_addr;
            s1_mask_reg <= 4'b0001 << yf_reg[1:0];
            s1_pix_reg  <= {2{bits_reg[7]}};
            s1_inv_reg  <= 1'b0;
        end

        if (ctl.result_load)
        begin
            read_byte_reg <= (is_read_reg && rd_ok_reg) ? rd_data_reg : 8'd0;
            refresh_reg   <= dirty_reg;
            clipped_reg   <= clip_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_byte       = read_byte_reg;
    assign refresh_pending = refresh_reg;
    assign clipped         = clipped_reg;

    property p_no_writeback_in_clear;
        @(posedge clk) disable iff (!rst_n)
        ctl.clr_step |-> !s1_valid_reg;
    endproperty
    a_no_writeback_in_clear: assert property (p_no_writeback_in_clear)
        else $error("write-back collides with clearing sweep");

    property p_result_into_free_slot;
        @(posedge clk) disable iff (!rst_n)
        ctl.result_load |-> (!out_valid_reg || out_ready);
    endproperty
    a_result_into_free_slot: assert property (p_result_into_free_slot)
        else $error("result overwrites an untaken result");

    property p_rect_column_in_range;
        @(posedge clk) disable iff (!rst_n)
        ctl.rect_step |-> (col_cnt_reg < XC_W'(pfb_pkg::COLUMNS));
    endproperty
    a_rect_column_in_range: assert property (p_rect_column_in_range)
        else $error("rectangle scan left the store");

endmodule

### design/packed_2bpp_framebuffer_ops.sv
// ----------------------------------------------------------------------------
// packed_2bpp_framebuffer_ops: 2bpp page-packed framebuffer with raster ops
// Keeps a framebuffer of 2-bit pixels, four vertically adjacent pixels to a
// byte, and runs fill, invert, bitmap, read and refresh acknowledge commands.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ------------------------------------------
//  input    in_valid / in_ready    cmd, x_first, y_first, x_last, y_last,
//                                  colour, bitmap_bits, bit_count, invert_bits
//  output   out_valid / out_ready  read_byte, refresh_pending, clipped
//
// Scan: a rectangle visits every byte it touches (columns times byte rows),
// and a bitmap steps once per bit of its clamped bit count; a read,
// acknowledge, the unused codes, an empty box and a bitmap with a count of
// zero do no scan. The single read-modify-write path into the store handles
// one byte per cycle.
// Reset: after rst_n is released a clearing sweep writes zero to all 4096
// bytes, one per cycle, and no transaction is accepted until it has finished.
// Stalls: a new command is accepted while the previous result still waits in
// the output register; it only holds in its last cycle until that register
// has been emptied.
//
module packed_2bpp_framebuffer_ops
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  cmd,
    input  logic [pfb_pkg::COORD_W-1:0] x_first,
    input  logic [pfb_pkg::COORD_W-1:0] y_first,
    input  logic [pfb_pkg::COORD_W-1:0] x_last,
    input  logic [pfb_pkg::COORD_W-1:0] y_last,
    input  logic [1:0]                  colour,
    input  logic [7:0]                  bitmap_bits,
    input  logic [3:0]                  bit_count,
    input  logic                        invert_bits,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  read_byte,
    output logic                        refresh_pending,
    output logic                        clipped
);

    // Commands from the sequencer to the datapath, and status back.
    pfb_pkg::pfb_ctl_t    ctl;
    pfb_pkg::pfb_status_t sts;

    // The sequencer decides which phase each cycle belongs to: sweep, scan,
    // drain or result. It sees only the command code of the incoming
    // transaction; everything else goes straight to the datapath.
    pfb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts),
        .ctl      (ctl)
    );

    // The datapath owns the store. Each scan cycle fetches one byte while the
    // byte fetched in the previous cycle is merged and written back, so the
    // store sustains one byte per cycle with a single read and a single write
    // port. Within a command every scanned byte is distinct, so the two never
    // touch the same address in the same cycle.
    pfb_dpath u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .cmd             (cmd),
        .x_first         (x_first),
        .y_first         (y_first),
        .x_last          (x_last),
        .y_last          (y_last),
        .colour          (colour),
        .bitmap_bits     (bitmap_bits),
        .bit_count       (bit_count),
        .invert_bits     (invert_bits),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_byte       (read_byte),
        .refresh_pending (refresh_pending),
        .clipped         (clipped)
    );

endmodule
